// ===== design/bnms_pkg.sv =====
// Shared types and constants for the box non-maximum suppression core.
`timescale 1ns / 1ps
package bnms_pkg;

    localparam int COORD_W   = 30;
    localparam int CLASS_W   = 32;
    localparam int SCORE_W   = 32;
    localparam int MAXOUT_W  = 7;
    localparam int THR_W     = 32;
    localparam int SLOT_W    = 6;
    localparam int DEF_MAX_KEPT = 64;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 192;

    localparam logic [1:0] REG_MAX_OUT   = 2'd0;
    localparam logic [1:0] REG_FORCE_SUP = 2'd1;
    localparam logic [1:0] REG_IOU_THR   = 2'd2;

    localparam logic [63:0] OV_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF / 64'd100;
    localparam logic [63:0] PCT      = 64'd100;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } box_rec_t;

    typedef struct packed {
        logic done;
        logic hit;
    } iou_res_t;

endpackage

// ===== design/box_non_max_suppression_core.sv =====
// Top level of the greedy box non-maximum suppression core with its kept-box memory.
//
//  channel | dir | handshake                  | payload
//  s_*     | in  | s_tvalid / s_tready        | s_tdata candidate, s_tlast list end
//  m_*     | out | m_tvalid / m_tready        | m_tdata echo + slot, m_tuser kept, m_tlast
//  cfg_*   | in  | cfg_we (no wait)           | cfg_index, cfg_data
//
// One request is handled at a time. Each kept box it is compared with is read from
// memory and class checked, then, on a class match or with force suppression set, put
// through an IoU on the serial 64-bit divider (after a divide by 100 if overlap is large).
// A kept box of another class is skipped without an IoU unless suppression is forced.
// Reset clears the kept count and the registers; memory contents need no clearing.
// A stalled output holds its result; the next request is taken once it is stored.
`timescale 1ns / 1ps
module box_non_max_suppression_core
#(
    parameter int MAX_KEPT = bnms_pkg::DEF_MAX_KEPT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // box_class, box_score, left, top, right, bottom
    input  logic [bnms_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // slot, out_class, out_score, out_left, out_top, out_right, out_bottom, zero pad
    output logic [bnms_pkg::OUT_DATA_W-1:0]      m_tdata,
    // kept
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [bnms_pkg::THR_W-1:0]           cfg_data
);
    import bnms_pkg::*;

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [MAXOUT_W-1:0]     max_out_reg;
    logic                    force_reg;
    logic signed [THR_W-1:0] thr_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             keep_reg, keep_next;

    box_rec_t           cand_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               last_reg;

    box_rec_t mem [MAX_KEPT];
    box_rec_t rd_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;

    logic     accept;
    logic     eligible;
    logic     out_free;
    logic     iou_start;
    logic     mem_we;
    iou_res_t iou_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign eligible = (32'(cnt_reg) < 32'(max_out_reg)) && (32'(cnt_reg) < 32'(MAX_KEPT))
                      && !s_tdata[CLASS_W-1];
    assign mem_we   = (state_reg == ST_FIN) && out_free && keep_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        keep_next  = keep_reg;
        iou_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    keep_next  = 1'b0;
                    state_next = eligible ? ST_RD : ST_FIN;
                end
            end
            ST_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    keep_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (force_reg || (rd_reg.cls == cand_reg.cls))
                begin
                    iou_start  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_WAIT:
            begin
                if (iou_res.done)
                begin
                    if (iou_res.hit)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    if (last_reg)
                    begin
                        cnt_next = '0;
                    end
                    else if (keep_reg)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            max_out_reg   <= MAXOUT_W'(DEF_MAX_KEPT);
            force_reg     <= 1'b0;
            thr_reg       <= THR_W'(50);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            keep_reg  <= keep_next;
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_OUT:   max_out_reg <= cfg_data[MAXOUT_W-1:0];
                    REG_FORCE_SUP: force_reg   <= cfg_data[0];
                    REG_IOU_THR:   thr_reg     <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg.cls    <= s_tdata[31:0];
            score_reg       <= s_tdata[63:32];
            cand_reg.left   <= s_tdata[93:64];
            cand_reg.top    <= s_tdata[123:94];
            cand_reg.right  <= s_tdata[153:124];
            cand_reg.bottom <= s_tdata[183:154];
            last_reg        <= s_tlast;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            out_data_reg <= {2'b00, cand_reg.bottom, cand_reg.right, cand_reg.top,
                             cand_reg.left, score_reg, cand_reg.cls,
                             keep_reg ? SLOT_W'(cnt_reg) : SLOT_W'(0)};
            out_user_reg <= keep_reg;
            out_last_reg <= last_reg;
        end
    end

    // Kept-box memory: the append at the fill count never meets a read below it.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= cand_reg;
        end
        rd_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    bnms_iou u_iou
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (iou_start),
        .kept_box (rd_reg),
        .cand_box (cand_reg),
        .thr      (thr_reg),
        .res      (iou_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/bnms_div.sv =====
// Radix-2 restoring divider for unsigned 64-bit operands, one quotient bit per cycle.
`timescale 1ns / 1ps
module bnms_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] shifted;

    assign shifted = {rem_reg[62:0], quo_reg[63]};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out of the top of quo while quotient bits enter below.
            if (shifted >= den_reg)
            begin
                rem_next = shifted - den_reg;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/bnms_iou.sv =====
// Percent IoU of a kept box and the candidate, compared against the threshold.
`timescale 1ns / 1ps
module bnms_iou
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  bnms_pkg::box_rec_t                kept_box,
    input  bnms_pkg::box_rec_t                cand_box,
    input  logic signed [bnms_pkg::THR_W-1:0] thr,
    output bnms_pkg::iou_res_t                res
);
    import bnms_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MA   = 4'd1;
    localparam logic [3:0] S_MB   = 4'd2;
    localparam logic [3:0] S_MO   = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_D2   = 4'd7;

    localparam logic [12:0] RECIP_100 = 13'd5243;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;
    logic       hit_reg, hit_next;

    logic signed [COORD_W:0] kw_reg, kh_reg, cw_reg, ch_reg, ow_reg, oh_reg;
    logic signed [COORD_W:0] kw_d, kh_d, cw_d, ch_d, ow_d, oh_d;
    logic signed [COORD_W-1:0] min_r, max_l, min_b, max_t;

    logic signed [COORD_W:0]     mul_a, mul_b;
    logic signed [2*COORD_W+1:0] prod;
    logic signed [63:0]          prod64;
    logic signed [63:0] area_a_reg, area_b_reg, ov_reg, sum_reg, den_sig;

    logic        div_start;
    logic [63:0] div_num, div_den, div_quo;
    logic        div_done;

    logic [63:0] d100_src_reg, d100_src_next;
    logic [63:0] d100_quo_reg, d100_quo_next;
    logic [6:0]  d100_rem_reg, d100_rem_next;
    logic [2:0]  d100_cnt_reg, d100_cnt_next;
    logic [14:0] d100_x;
    logic [27:0] d100_prod;
    logic [7:0]  d100_q;
    logic [6:0]  d100_r;

    logic hit_zero;
    logic hit_quo;

    // Extents of both boxes and of their overlap, clamped at zero for the overlap.
    always_comb
    begin
        min_r = ($signed(kept_box.right) < $signed(cand_box.right)) ?
                $signed(kept_box.right) : $signed(cand_box.right);
        max_l = ($signed(kept_box.left) > $signed(cand_box.left)) ?
                $signed(kept_box.left) : $signed(cand_box.left);
        min_b = ($signed(kept_box.bottom) < $signed(cand_box.bottom)) ?
                $signed(kept_box.bottom) : $signed(cand_box.bottom);
        max_t = ($signed(kept_box.top) > $signed(cand_box.top)) ?
                $signed(kept_box.top) : $signed(cand_box.top);
        kw_d = $signed({kept_box.right[COORD_W-1], kept_box.right})
             - $signed({kept_box.left[COORD_W-1], kept_box.left});
        kh_d = $signed({kept_box.bottom[COORD_W-1], kept_box.bottom})
             - $signed({kept_box.top[COORD_W-1], kept_box.top});
        cw_d = $signed({cand_box.right[COORD_W-1], cand_box.right})
             - $signed({cand_box.left[COORD_W-1], cand_box.left});
        ch_d = $signed({cand_box.bottom[COORD_W-1], cand_box.bottom})
             - $signed({cand_box.top[COORD_W-1], cand_box.top});
        ow_d = $signed({min_r[COORD_W-1], min_r}) - $signed({max_l[COORD_W-1], max_l});
        oh_d = $signed({min_b[COORD_W-1], min_b}) - $signed({max_t[COORD_W-1], max_t});
        if (ow_d[COORD_W])
        begin
            ow_d = '0;
        end
        if (oh_d[COORD_W])
        begin
            oh_d = '0;
        end
    end

    // One shared multiplier, fed by the step that is running.
    always_comb
    begin
        case (state_reg)
            S_MA:
            begin
                mul_a = kw_reg;
                mul_b = kh_reg;
            end
            S_MB:
            begin
                mul_a = cw_reg;
                mul_b = ch_reg;
            end
            default:
            begin
                mul_a = ow_reg;
                mul_b = oh_reg;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign prod64  = {{(64-2*COORD_W-2){prod[2*COORD_W+1]}}, prod};
    assign den_sig = sum_reg - ov_reg;

    // The denominator is divided by 100 one byte per cycle; each quotient digit comes
    // from a reciprocal multiply that is exact below 25600.
    assign d100_x    = {d100_rem_reg, d100_src_reg[63:56]};
    assign d100_prod = 28'(d100_x) * 28'(RECIP_100);
    assign d100_q    = d100_prod[26:19];
    assign d100_r    = 7'(d100_x - 15'(d100_q) * 15'(PCT));

    assign hit_zero = thr[THR_W-1] || (thr == '0);
    assign hit_quo  = thr[THR_W-1] || (div_quo >= {{(64-THR_W){1'b0}}, thr});

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        hit_next      = hit_reg;
        div_start     = 1'b0;
        div_num       = 64'(ov_reg);
        div_den       = 64'(den_sig);
        d100_src_next = d100_src_reg;
        d100_quo_next = d100_quo_reg;
        d100_rem_next = d100_rem_reg;
        d100_cnt_next = d100_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                state_next = S_MB;
            end
            S_MB:
            begin
                state_next = S_MO;
            end
            S_MO:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sum_reg[63] || (sum_reg == '0) || den_sig[63] || (den_sig == '0))
                begin
                    hit_next   = hit_zero;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (64'(ov_reg) > OV_LIMIT)
                begin
                    // Large overlap: scale the denominator down instead of the overlap up.
                    d100_src_next = 64'(den_sig);
                    d100_quo_next = '0;
                    d100_rem_next = '0;
                    d100_cnt_next = '0;
                    state_next    = S_D1;
                end
                else
                begin
                    div_num    = (64'(ov_reg) << 6) + (64'(ov_reg) << 5) + (64'(ov_reg) << 2);
                    div_den    = 64'(den_sig);
                    div_start  = 1'b1;
                    state_next = S_D2;
                end
            end
            S_D1:
            begin
                d100_quo_next = {d100_quo_reg[55:0], d100_q};
                d100_rem_next = d100_r;
                d100_src_next = {d100_src_reg[55:0], 8'h00};
                d100_cnt_next = d100_cnt_reg + 3'd1;
                if (d100_cnt_reg == 3'd7)
                begin
                    if (d100_quo_next == '0)
                    begin
                        hit_next   = hit_zero;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        div_num    = 64'(ov_reg);
                        div_den    = d100_quo_next;
                        div_start  = 1'b1;
                        state_next = S_D2;
                    end
                end
            end
            S_D2:
            begin
                if (div_done)
                begin
                    hit_next   = hit_quo;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d100_src_reg <= d100_src_next;
        d100_quo_reg <= d100_quo_next;
        d100_rem_reg <= d100_rem_next;
        d100_cnt_reg <= d100_cnt_next;
        if (state_reg == S_IDLE && start)
        begin
            kw_reg <= kw_d;
            kh_reg <= kh_d;
            cw_reg <= cw_d;
            ch_reg <= ch_d;
            ow_reg <= ow_d;
            oh_reg <= oh_d;
        end
        if (state_reg == S_MA)
        begin
            area_a_reg <= prod64;
        end
        if (state_reg == S_MB)
        begin
            area_b_reg <= prod64;
        end
        if (state_reg == S_MO)
        begin
            ov_reg <= prod64;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= area_a_reg + area_b_reg;
        end
    end

    bnms_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign res.done = done_reg;
    assign res.hit  = hit_reg;

endmodule

// ===== design/bnms_checker.sv =====
// Port-level checks for the box non-maximum suppression core, bound to the top level.
`timescale 1ns / 1ps
module bnms_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [bnms_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                               m_tuser
);
    import bnms_pkg::*;

    // The output register comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result present right after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A candidate that is not kept reports slot zero.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[SLOT_W-1:0] == '0)
        else $error("nonzero slot on a box that was not kept");

    // Only one request is in work: after a take the input is closed in the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

endmodule

bind box_non_max_suppression_core bnms_checker u_bnms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the box non-maximum suppression core.
`timescale 1ns / 1ps
module testbench;
    import bnms_pkg::*;

    typedef struct {
        logic [31:0] cls;
        logic [31:0] score;
        logic [29:0] l, t, r, b;
        logic        fin;
    } cand_t;

    typedef struct {
        logic        kept;
        logic [5:0]  slot;
        logic [31:0] cls;
        logic [31:0] score;
        logic [29:0] l, t, r, b;
        logic        fin;
    } verdict_t;

    class nms_scoreboard;
        logic [6:0]  max_out = 7'd64;
        logic        force_sup = 1'b0;
        logic [31:0] thr = 32'd50;
        int          count = 0;
        logic [31:0] k_cls[64];
        longint      k_l[64], k_t[64], k_r[64], k_b[64];
        verdict_t    pending[$];
        int          errors = 0;

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_MAX_OUT) max_out = val[6:0];
            else if (idx == REG_FORCE_SUP) force_sup = val[0];
            else if (idx == REG_IOU_THR) thr = val;
        endfunction

        function longint overlap_pct(longint ax0, longint ay0, longint ax1, longint ay1,
                                     longint bx0, longint by0, longint bx1, longint by1);
            longint sum, w, h, ov, den;
            sum = (ax1 - ax0) * (ay1 - ay0) + (bx1 - bx0) * (by1 - by0);
            if (sum <= 0) return 0;
            w = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
            h = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
            if (w < 0) w = 0;
            if (h < 0) h = 0;
            ov = h * w;
            den = sum - ov;
            if (den <= 0) return 0;
            // Large overlaps would overflow when scaled, so the divisor shrinks instead.
            if (longint'(64'h7FFF_FFFF_FFFF_FFFF) / 100 < ov) den = den / 100;
            else ov = ov * 100;
            if (den == 0) return 0;
            return ov / den;
        endfunction

        function void note(cand_t c);
            verdict_t v;
            int       lim;
            bit       sup;
            longint   l, t, r, b;
            l = $signed(c.l);
            t = $signed(c.t);
            r = $signed(c.r);
            b = $signed(c.b);
            lim = (max_out > 64) ? 64 : int'(max_out);
            v.kept = 0;
            v.slot = 0;
            if (count < lim && !c.cls[31]) begin
                sup = 0;
                for (int i = 0; i < count; i++) begin
                    if ((force_sup || k_cls[i] == c.cls) &&
                        overlap_pct(k_l[i], k_t[i], k_r[i], k_b[i], l, t, r, b)
                            >= longint'($signed(thr))) begin
                        sup = 1;
                        break;
                    end
                end
                if (!sup) begin
                    k_cls[count] = c.cls;
                    k_l[count] = l;
                    k_t[count] = t;
                    k_r[count] = r;
                    k_b[count] = b;
                    v.kept = 1;
                    v.slot = count[5:0];
                    count++;
                end
            end
            v.cls = c.cls;
            v.score = c.score;
            v.l = c.l;
            v.t = c.t;
            v.r = c.r;
            v.b = c.b;
            v.fin = c.fin;
            if (c.fin) count = 0;
            pending.push_back(v);
        endfunction

        function void fail(string what);
            errors++;
            if (errors <= 10) $display("mismatch: %s", what);
        endfunction

        function void check(verdict_t a);
            verdict_t e;
            if (pending.size() == 0) begin
                fail("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (a.kept !== e.kept) fail($sformatf("kept exp %0d got %0d", e.kept, a.kept));
            if (a.slot !== e.slot) fail($sformatf("slot exp %0d got %0d", e.slot, a.slot));
            if (a.cls !== e.cls) fail($sformatf("class exp %h got %h", e.cls, a.cls));
            if (a.score !== e.score) fail($sformatf("score exp %h got %h", e.score, a.score));
            if (a.l !== e.l) fail($sformatf("left exp %h got %h", e.l, a.l));
            if (a.t !== e.t) fail($sformatf("top exp %h got %h", e.t, a.t));
            if (a.r !== e.r) fail($sformatf("right exp %h got %h", e.r, a.r));
            if (a.b !== e.b) fail($sformatf("bottom exp %h got %h", e.b, a.b));
            if (a.fin !== e.fin) fail($sformatf("list end exp %0d got %0d", e.fin, a.fin));
        endfunction
    endclass

    localparam int IDLE_LIMIT = 50000;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 0;
    logic [1:0]            cfg_index = REG_MAX_OUT;
    logic [THR_W-1:0]      cfg_data = '0;

    nms_scoreboard sb = new();
    bit            calm = 0;
    int            results = 0;
    int            quiet = 0;

    box_non_max_suppression_core i_dut (.*);

    always #5 clk = ~clk;

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_config(int mo, int fs, int thr);
        wait (sb.pending.size() == 0);
        repeat (20) @(negedge clk);
        cfg_write(REG_MAX_OUT, mo);
        cfg_write(REG_FORCE_SUP, fs);
        cfg_write(REG_IOU_THR, thr);
    endtask

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance.
    task automatic send(cand_t c);
        if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk);
        s_tvalid = 1;
        s_tdata = {c.b, c.r, c.t, c.l, c.score, c.cls};
        s_tlast = c.fin;
        do @(posedge clk); while (!s_tready);
        sb.note(c);
        @(negedge clk);
        s_tvalid = 0;
    endtask

    function automatic cand_t mk(logic [31:0] cls, logic [31:0] score, int l, int t,
                                 int r, int b, logic fin);
        cand_t c;
        c.cls = cls;
        c.score = score;
        c.l = 30'(l);
        c.t = 30'(t);
        c.r = 30'(r);
        c.b = 30'(b);
        c.fin = fin;
        return c;
    endfunction

    function automatic cand_t rand_cand();
        cand_t c;
        int    x, y, k;
        k = $urandom_range(0, 99);
        x = $urandom_range(0, 200) - 100;
        y = $urandom_range(0, 200) - 100;
        c = mk($urandom_range(0, 3), $urandom, x, y, x + $urandom_range(1, 80),
               y + $urandom_range(1, 80), $urandom_range(0, 5) == 0);
        if (k < 8) begin
            c.l = 30'($urandom);
            c.t = 30'($urandom);
            c.r = 30'($urandom);
            c.b = 30'($urandom);
        end else if (k < 12) begin
            // Huge boxes drive the overlap past the scaling limit.
            c.l = 30'(30'h2000_0000 + $urandom_range(0, 1000));
            c.t = 30'(30'h2000_0000 + $urandom_range(0, 1000));
            c.r = 30'(30'h1FFF_FFFF - $urandom_range(0, 1000));
            c.b = 30'(30'h1FFF_FFFF - $urandom_range(0, 1000));
        end else if (k < 15) begin
            c.r = 30'(c.l - $urandom_range(0, 5));
        end
        if (k % 17 == 0) c.cls = $urandom;
        else if (k % 19 == 0) c.cls = 32'h8000_0000 | $urandom;
        return c;
    endfunction

    always @(posedge clk) begin
        verdict_t a;
        if (m_tvalid && m_tready) begin
            a.slot = m_tdata[5:0];
            a.cls = m_tdata[37:6];
            a.score = m_tdata[69:38];
            a.l = m_tdata[99:70];
            a.t = m_tdata[129:100];
            a.r = m_tdata[159:130];
            a.b = m_tdata[189:160];
            a.kept = m_tuser;
            a.fin = m_tlast;
            sb.check(a);
            results++;
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet = 0;
        else quiet++;
    end

    initial begin
        wait (quiet >= IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int hold, burst;
        bit held;
        hold = 0;
        burst = 0;
        held = 0;
        forever begin
            @(negedge clk);
            if (!held && results >= 400) begin
                held = 1;
                hold = 3000;
            end
            if (hold > 0) begin
                m_tready = 0;
                hold--;
            end else if (burst > 0) begin
                m_tready = 0;
                burst--;
            end else begin
                m_tready = 1;
                if (!calm && $urandom_range(0, 4) == 0) burst = $urandom_range(1, 6);
            end
        end
    end

    initial begin
        int settings[7][3];
        settings = '{'{64, 0, 50}, '{3, 1, 30}, '{127, 1, -5}, '{64, 0, 32'h7FFF_FFFF},
                     '{1, 0, 32'h8000_0000}, '{64, 1, 0}, '{40, 0, 20}};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // Same class suppression, other class kept, invalid class, extremes.
        send(mk(0, 100, 0, 0, 10, 10, 0));
        send(mk(0, 99, 0, 0, 10, 10, 0));
        send(mk(1, 98, 0, 0, 10, 10, 0));
        send(mk(32'h8000_0000, 97, 0, 0, 10, 10, 0));
        send(mk(32'hFFFF_FFFF, 97, 1, 1, 5, 5, 0));
        send(mk(0, 96, 32'hE000_0000, 32'hE000_0000, 30'h1FFF_FFFF, 30'h1FFF_FFFF, 0));
        send(mk(0, 95, 32'hE000_0000, 32'hE000_0000, 30'h1FFF_FFFF, 30'h1FFF_FFFF, 0));
        send(mk(2, 94, 20, 20, 15, 30, 0));
        send(mk(32'h7FFF_FFFF, 32'h8000_0000, 30'h1FFF_FFFF, 0, 32'hE000_0000, 0, 0));
        send(mk(3, 32'h7FFF_FFFF, 0, 0, 0, 0, 1));
        // Full table.
        set_config(2, 0, 32'h7FFF_FFFF);
        send(mk(0, 1, 0, 0, 4, 4, 0));
        send(mk(0, 1, 0, 0, 4, 4, 0));
        send(mk(0, 1, 0, 0, 4, 4, 1));
        // No room at all.
        set_config(0, 1, 50);
        send(mk(0, 1, 0, 0, 4, 4, 1));
        // Negative threshold across classes.
        set_config(64, 1, -1);
        send(mk(0, 1, 0, 0, 4, 4, 0));
        send(mk(5, 1, 100, 100, 104, 104, 0));
        send(mk(6, 1, 0, 0, 1, 1, 1));

        for (int p = 0; p < 7; p++) begin
            set_config(settings[p][0], settings[p][1], settings[p][2]);
            if (p == 6) calm = 1;
            for (int n = 0; n < 260; n++) send(rand_cand());
            send(mk(0, 0, 0, 0, 1, 1, 1));
        end

        wait (sb.pending.size() == 0);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
